@@ design/bfd_pkg.sv @@
// Package for the bounded FIFO with contents dump.
// Holds request and result types, status and request codes, sequencer states.
// No dependencies.
package bfd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 7;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned DepthDef = 64;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  localparam logic       ReqEnq = 1'b0;
  localparam logic       ReqDeq = 1'b1;

  localparam logic [1:0] StElem     = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SizeW-1:0]        size;
    logic signed [DataW-1:0] element;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SizeW-1:0] size;
    logic             last;
  } rsp_meta_t;

endpackage

@@ design/bounded_fifo_with_dump.sv @@
// An overflow or empty result is registered straight from the accepted request. A listing
// request moves the sequencer to S_LIST, which reads the slot memory through one read port,
// one element per cycle while the result side is ready; no request is taken during a listing.
// Reset (rst_ni low, async): queue empty, head at zero, capacity 64, no result.
// Slot memory is not cleared; only written slots are ever listed. Depends on bfd_pkg.
module bounded_fifo_with_dump
  import bfd_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;

  logic [DataW-1:0] mem [DEPTH];

  state_e            state_q, state_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   list_ptr_q, list_ptr_d;
  logic [CntW-1:0]   list_idx_q, list_idx_d;
  logic [CapW-1:0]   cap_q;
  logic              out_valid_q, out_valid_d;
  rsp_meta_t         meta_q, meta_d;
  logic [DataW-1:0]  elem_q;

  logic              in_fire, out_free, full, list_last;
  logic              mem_we, rd_en, elem_clr;
  logic [LimW-1:0]   cap_ext, depth_ext, limit;
  logic [SumW-1:0]   wr_sum;
  logic [PtrW-1:0]   wr_addr, head_next, list_ptr_next;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cap_ext   = LimW'(cap_q);
  assign depth_ext = LimW'(DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign full      = LimW'(count_q) >= limit;

  assign wr_sum  = SumW'(head_q) + SumW'(count_q);
  assign wr_addr = (wr_sum >= SumW'(DEPTH)) ? PtrW'(wr_sum - SumW'(DEPTH)) : PtrW'(wr_sum);

  assign head_next     = ptr_inc(head_q);
  assign list_ptr_next = ptr_inc(list_ptr_q);
  assign list_last     = (list_idx_q + CntW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    list_ptr_d  = list_ptr_q;
    list_idx_d  = list_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    meta_d      = meta_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    elem_clr    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.req_type == ReqEnq) begin
            if (full) begin
              meta_d      = '{status: StOverflow, size: SizeW'(count_q), last: 1'b1};
              out_valid_d = 1'b1;
              elem_clr    = 1'b1;
            end else begin
              mem_we     = 1'b1;
              count_d    = count_q + CntW'(1);
              list_ptr_d = head_q;
              list_idx_d = '0;
              state_d    = S_LIST;
            end
          end else begin
            if (count_q == '0) begin
              meta_d      = '{status: StEmpty, size: '0, last: 1'b1};
              out_valid_d = 1'b1;
              elem_clr    = 1'b1;
            end else begin
              head_d  = head_next;
              count_d = count_q - CntW'(1);
              if (count_q == CntW'(1)) begin
                meta_d      = '{status: StEmpty, size: '0, last: 1'b1};
                out_valid_d = 1'b1;
                elem_clr    = 1'b1;
              end else begin
                list_ptr_d = head_next;
                list_idx_d = '0;
                state_d    = S_LIST;
              end
            end
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          rd_en       = 1'b1;
          meta_d      = '{status: StElem, size: SizeW'(count_q), last: list_last};
          out_valid_d = 1'b1;
          list_ptr_d  = list_ptr_next;
          list_idx_d  = list_idx_q + CntW'(1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      list_ptr_q  <= '0;
      list_idx_q  <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      list_ptr_q  <= list_ptr_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
    if (mem_we) begin
      mem[wr_addr] <= in_i.value;
    end
    if (rd_en) begin
      elem_q <= mem[list_ptr_q];
    end else if (elem_clr) begin
      elem_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = '{status:  meta_q.status,
                         size:    meta_q.size,
                         element: elem_q,
                         last:    meta_q.last};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (list_idx_q < count_q))
    else $error("listing index past count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && out_valid_q) |-> meta_q.last)
    else $error("held result in idle is not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.req_type == ReqEnq && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("enqueue did not grow the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.req_type == ReqEnq && full) |=> (count_q == $past(count_q)
      && out_valid_q && meta_q.status == StOverflow))
    else $error("overflow altered queue or gave no overflow result");

endmodule
